>>> src/rsfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsfb_pkg
// Shared constants, types and pixel format helpers of the rolling scanline
// frame buffer.
// ----------------------------------------------------------------------------
package rsfb_pkg;

    localparam int LINE_WIDTH    = 256;
    localparam int FRAME_HEIGHT  = 240;
    localparam int VISIBLE_LINES = 240;
    localparam int TOTAL_LINES   = 262;
    localparam int LINE_PERIOD   = 320;
    localparam int NUM_BANKS     = 8;

    localparam int BEAM_W      = 9;
    localparam int PEND_W      = 4;
    localparam int XW          = $clog2(LINE_WIDTH);
    localparam int SLOT_W      = $clog2(NUM_BANKS * 2);
    localparam int NSLOT       = 1 << SLOT_W;
    localparam int YW          = $clog2(FRAME_HEIGHT);
    localparam int FILL_W      = $clog2(FRAME_HEIGHT + 1);
    localparam int SA_W        = SLOT_W + XW;
    localparam int FA_W        = YW + XW;
    localparam int STORE_DEPTH = 1 << SA_W;
    localparam int FRAME_DEPTH = FRAME_HEIGHT << XW;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WR16  = 3'd1;
    localparam logic [2:0] OP_WR32  = 3'd2;
    localparam logic [2:0] OP_LREAD = 3'd3;
    localparam logic [2:0] OP_FREAD = 3'd4;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_BLOCK = 1'b1;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_WRITE,
        CMD_LREAD,
        CMD_FREAD
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [XW-1:0]     x;
        logic [BEAM_W-1:0] y;
        logic [31:0]       data;
    } item_t;

    typedef struct packed {
        logic mode;
        logic block_clear;
    } cfg_t;

    // BGR555A1 -> RGBA8888
    function automatic logic [31:0] expand16(input logic [15:0] c);
        return {c[5:1], c[5:3], c[10:6], c[10:8], c[15:11], c[15:13], {8{c[0]}}};
    endfunction

    // RGBA8888 -> BGR555A1, alpha set when A > 127
    function automatic logic [15:0] reduce32(input logic [31:0] c);
        return {c[15:11], c[23:19], c[31:27], c[7]};
    endfunction

endpackage
`default_nettype wire

>>> src/rolling_scanline_framebuffer_unit.sv
`default_nettype none
// Writes, reads and ticks that stay within a line go straight to the result
// register. A tick that ends a visible line adds the line latch, the line step
// and the window steps, clearing each written slot that the window leaves; a
// frame wrap or render_mode change walks all 16 slots and clears each written
// one. A new item is taken only once the previous one has finished.
// Reset: after rst_n the line store is swept clear (all 16 slots).
// ----------------------------------------------------------------------------
// rolling_scanline_framebuffer_unit
// Beam-timed rolling scanline buffer with an output frame store and an APB
// register port for render mode and block clearing.
// ----------------------------------------------------------------------------
module rolling_scanline_framebuffer_unit import rsfb_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [9:0]  pos_x,
    input  wire logic [9:0]  pos_y,
    input  wire logic [31:0] color,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [31:0]      pixel,
    output logic             found,
    output logic [8:0]       beam_row,
    output logic [8:0]       beam_col
);

    logic  mode_reg;
    logic  block_reg;
    logic  cfg_wr;
    logic  mode_flip;
    cfg_t  cfg;
    logic  q_full;
    logic  push;
    item_t fe_item;
    logic  q_pop;
    item_t q_item;
    logic  q_valid;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign mode_flip = cfg_wr && (paddr[2] == REG_MODE) && (pwdata[0] != mode_reg);
    assign cfg.mode        = mode_reg;
    assign cfg.block_clear = block_reg;
    assign prdata    = {31'b0, (paddr[2] == REG_BLOCK) ? block_reg : mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            block_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_BLOCK)
            begin
                block_reg <= pwdata[0];
            end
            else
            begin
                mode_reg <= pwdata[0];
            end
        end
    end

    rsfb_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .color      (color),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .item       (fe_item)
    );

    rsfb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fe_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_item),
        .valid (q_valid)
    );

    rsfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .mode_flip    (mode_flip),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel        (pixel),
        .found        (found),
        .beam_row     (beam_row),
        .beam_col     (beam_col)
    );

endmodule
`default_nettype wire

>>> src/rsfb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsfb_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/rsfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsfb_front
// Input side: range checks, command classification and pixel conversion to
// the current render mode.
// ----------------------------------------------------------------------------
module rsfb_front import rsfb_pkg::*; (
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [9:0]  pos_x,
    input  wire logic [9:0]  pos_y,
    input  wire logic [31:0] color,
    input  wire cfg_t        cfg,
    input  wire logic        q_full,
    output logic             push,
    output item_t            item
);

    logic x_ok;
    logic y_ok;
    logic pos_ok;
    logic is16;

    assign x_ok   = !pos_x[9] && ({1'b0, pos_x[8:0]} < 10'(LINE_WIDTH));
    assign y_ok   = !pos_y[9] && ({1'b0, pos_y[8:0]} < 10'(FRAME_HEIGHT));
    assign pos_ok = x_ok && y_ok;
    assign is16   = (operation == OP_WR16);

    assign item_ready = !q_full;
    assign push       = item_valid && !q_full;

    always_comb
    begin
        item.x = pos_x[XW-1:0];
        item.y = pos_y[8:0];
        if (cfg.mode)
        begin
            item.data = is16 ? expand16(color[15:0]) : color;
        end
        else
        begin
            item.data = is16 ? {16'b0, color[15:0]} : {16'b0, reduce32(color)};
        end
        case (operation)
            OP_TICK:  item.cmd = CMD_TICK;
            OP_LREAD: item.cmd = pos_ok ? CMD_LREAD : CMD_NOP;
            OP_FREAD: item.cmd = pos_ok ? CMD_FREAD : CMD_NOP;
            default:
            begin
                if (operation inside {OP_WR16, OP_WR32})
                begin
                    item.cmd = pos_ok ? CMD_WRITE : CMD_NOP;
                end
                else
                begin
                    item.cmd = CMD_NOP;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/rsfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsfb_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rsfb_queue import rsfb_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t din,
    output logic       full,
    input  wire logic  pop,
    output item_t      dout,
    output logic       valid
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

>>> src/rsfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsfb_back
// Execution side: beam timing, rolling line store, line latch into the
// output frame, window slide with slot clears, and the result register.
// ----------------------------------------------------------------------------
module rsfb_back import rsfb_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        mode_flip,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [31:0]      pixel,
    output logic             found,
    output logic [8:0]       beam_row,
    output logic [8:0]       beam_col
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_LATCH,
        S_LINE,
        S_SLIDE,
        S_CLR,
        S_WIPE
    } state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_ZERO,
        SRC_STORE,
        SRC_FRAME
    } src_t;

    state_t              state_reg;
    src_t                src_reg;
    logic [BEAM_W-1:0]   beam_pixel_reg;
    logic [BEAM_W-1:0]   beam_line_reg;
    logic [BEAM_W-1:0]   ws_reg;
    logic [SLOT_W-1:0]   ws_slot_reg;
    logic                pend_v_reg;
    logic [PEND_W-1:0]   pend_slot_reg;
    logic [NSLOT-1:0]    dirty_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                wipe_req_reg;
    logic                wipe_item_reg;
    logic [SLOT_W-1:0]   wipe_idx_reg;
    logic [SLOT_W-1:0]   clr_slot_reg;
    logic [SLOT_W-1:0]   clr2_slot_reg;
    logic                clr2_v_reg;
    logic [XW-1:0]       clr_cnt_reg;
    logic                ret_slide_reg;
    logic [BEAM_W-1:0]   lat_y_reg;
    logic [XW:0]         lat_cnt_reg;
    logic [BEAM_W-1:0]   target_reg;
    logic                out_valid_reg;
    logic [31:0]         out_pixel_reg;
    logic                out_found_reg;
    logic [8:0]          out_row_reg;
    logic [8:0]          out_col_reg;

    logic [SLOT_W:0]     win;
    logic [BEAM_W-1:0]   y_sel;
    logic [BEAM_W:0]     rel;
    logic                in_win;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   y_slot;
    logic                start;
    logic [BEAM_W-1:0]   tick_pix;
    logic                lat_cond;
    logic [BEAM_W:0]     line_nx;
    logic [SLOT_W-1:0]   pend_as_slot;
    logic                step_clear;
    logic [31:0]         store_pix;

    logic                st_we;
    logic [SA_W-1:0]     st_waddr;
    logic [31:0]         st_wdata;
    logic [SA_W-1:0]     st_raddr;
    logic [31:0]         st_rdata;
    logic                fr_we;
    logic [FA_W-1:0]     fr_waddr;
    logic [31:0]         fr_wdata;
    logic [FA_W-1:0]     fr_raddr;
    logic [31:0]         fr_rdata;

    rsfb_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rsfb_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH)) u_frame (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    // window lookup: scanline -> slot, shared by item access and line latch
    assign win      = cfg.mode ? (SLOT_W+1)'(NUM_BANKS) : (SLOT_W+1)'(2 * NUM_BANKS);
    assign y_sel    = (state_reg == S_LATCH) ? lat_y_reg : q_item.y;
    assign rel      = {1'b0, y_sel} - {1'b0, ws_reg};
    assign in_win   = !rel[BEAM_W] && (rel[BEAM_W-1:0] < BEAM_W'(win));
    assign slot_sum = {1'b0, ws_slot_reg} + rel[SLOT_W:0];
    assign y_slot   = (slot_sum >= win) ? SLOT_W'(slot_sum - win) : SLOT_W'(slot_sum);

    assign start = (state_reg == S_IDLE) && !wipe_req_reg && q_valid &&
                   (!out_valid_reg || result_ready);
    assign q_pop = start;

    assign tick_pix     = beam_pixel_reg + 1'b1;
    assign lat_cond     = (beam_line_reg != '0) &&
                          ({1'b0, beam_line_reg} <= (BEAM_W+1)'(VISIBLE_LINES)) &&
                          ({1'b0, beam_line_reg} <= (BEAM_W+1)'(FRAME_HEIGHT));
    assign line_nx      = {1'b0, beam_line_reg} + 1'b1;
    assign pend_as_slot = SLOT_W'(pend_slot_reg);
    assign step_clear   = !cfg.block_clear || cfg.mode || ws_slot_reg[0];
    assign store_pix    = cfg.mode ? st_rdata : expand16(st_rdata[15:0]);

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = {y_slot, q_item.x};
        st_wdata = q_item.data;
        if (state_reg == S_CLR)
        begin
            st_we    = 1'b1;
            st_waddr = {clr_slot_reg, clr_cnt_reg};
            st_wdata = '0;
        end
        else if (start && (q_item.cmd == CMD_WRITE) && in_win)
        begin
            st_we = 1'b1;
        end
        st_raddr = (state_reg == S_LATCH) ? {y_slot, lat_cnt_reg[XW-1:0]}
                                          : {y_slot, q_item.x};
        // each latch write stores the pixel read from the store in the cycle before
        fr_we    = (state_reg == S_LATCH) && (lat_cnt_reg != '0);
        fr_waddr = {lat_y_reg[YW-1:0], XW'(lat_cnt_reg - 1'b1)};
        fr_wdata = in_win ? store_pix : '0;
        fr_raddr = {q_item.y[YW-1:0], q_item.x};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            src_reg        <= SRC_NONE;
            beam_pixel_reg <= '0;
            beam_line_reg  <= '0;
            ws_reg         <= '0;
            ws_slot_reg    <= '0;
            pend_v_reg     <= 1'b0;
            pend_slot_reg  <= '0;
            dirty_reg      <= '1;
            fill_reg       <= '0;
            wipe_req_reg   <= 1'b1;
            wipe_item_reg  <= 1'b0;
            wipe_idx_reg   <= '0;
            clr_slot_reg   <= '0;
            clr2_slot_reg  <= '0;
            clr2_v_reg     <= 1'b0;
            clr_cnt_reg    <= '0;
            ret_slide_reg  <= 1'b0;
            lat_y_reg      <= '0;
            lat_cnt_reg    <= '0;
            target_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_pixel_reg  <= '0;
            out_found_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mode_flip)
            begin
                ws_reg        <= '0;
                ws_slot_reg   <= '0;
                pend_v_reg    <= 1'b0;
                pend_slot_reg <= '0;
                wipe_req_reg  <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (wipe_req_reg)
                    begin
                        wipe_idx_reg  <= '0;
                        wipe_item_reg <= 1'b0;
                        state_reg     <= S_WIPE;
                    end
                    else if (start)
                    begin
                        src_reg   <= SRC_NONE;
                        state_reg <= S_FIN;
                        case (q_item.cmd)
                            CMD_TICK:
                            begin
                                if (tick_pix < BEAM_W'(LINE_PERIOD))
                                begin
                                    beam_pixel_reg <= tick_pix;
                                end
                                else if (lat_cond)
                                begin
                                    lat_y_reg   <= beam_line_reg - 1'b1;
                                    lat_cnt_reg <= '0;
                                    state_reg   <= S_LATCH;
                                end
                                else
                                begin
                                    state_reg <= S_LINE;
                                end
                            end
                            CMD_WRITE:
                            begin
                                if (in_win)
                                begin
                                    dirty_reg[y_slot] <= 1'b1;
                                end
                            end
                            CMD_LREAD:
                            begin
                                if (in_win)
                                begin
                                    src_reg <= SRC_STORE;
                                end
                            end
                            CMD_FREAD:
                            begin
                                // rows not latched since reset still read as zero
                                if ({1'b0, q_item.y} < (BEAM_W+1)'(fill_reg))
                                begin
                                    src_reg <= SRC_FRAME;
                                end
                                else
                                begin
                                    src_reg <= SRC_ZERO;
                                end
                            end
                            default:
                            begin
                                src_reg <= SRC_NONE;
                            end
                        endcase
                    end
                end
                S_LATCH:
                begin
                    if (lat_cnt_reg == (XW+1)'(LINE_WIDTH))
                    begin
                        if ({1'b0, lat_y_reg} >= (BEAM_W+1)'(fill_reg))
                        begin
                            fill_reg <= FILL_W'({1'b0, lat_y_reg} + 1'b1);
                        end
                        state_reg <= S_LINE;
                    end
                    else
                    begin
                        lat_cnt_reg <= lat_cnt_reg + 1'b1;
                    end
                end
                S_LINE:
                begin
                    beam_pixel_reg <= '0;
                    if (line_nx >= (BEAM_W+1)'(TOTAL_LINES))
                    begin
                        beam_line_reg <= '0;
                        ws_reg        <= '0;
                        ws_slot_reg   <= '0;
                        pend_v_reg    <= 1'b0;
                        pend_slot_reg <= '0;
                        wipe_idx_reg  <= '0;
                        wipe_item_reg <= 1'b1;
                        state_reg     <= S_WIPE;
                    end
                    else
                    begin
                        beam_line_reg <= line_nx[BEAM_W-1:0];
                        if (line_nx <= (BEAM_W+1)'(VISIBLE_LINES))
                        begin
                            target_reg <= beam_line_reg;
                            state_reg  <= S_SLIDE;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_SLIDE:
                begin
                    if (ws_reg >= target_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ws_reg <= ws_reg + 1'b1;
                        if (({1'b0, ws_slot_reg} + 1'b1) == win)
                        begin
                            ws_slot_reg <= '0;
                        end
                        else
                        begin
                            ws_slot_reg <= ws_slot_reg + 1'b1;
                        end
                        ret_slide_reg <= 1'b1;
                        clr_cnt_reg   <= '0;
                        if (step_clear)
                        begin
                            pend_v_reg <= 1'b0;
                            // clean slots are already zero, skip them
                            if (pend_v_reg && dirty_reg[pend_as_slot])
                            begin
                                clr_slot_reg  <= pend_as_slot;
                                clr2_slot_reg <= ws_slot_reg;
                                clr2_v_reg    <= dirty_reg[ws_slot_reg];
                                state_reg     <= S_CLR;
                            end
                            else if (dirty_reg[ws_slot_reg])
                            begin
                                clr_slot_reg <= ws_slot_reg;
                                clr2_v_reg   <= 1'b0;
                                state_reg    <= S_CLR;
                            end
                        end
                        else
                        begin
                            pend_v_reg    <= 1'b1;
                            pend_slot_reg <= PEND_W'(ws_slot_reg);
                        end
                    end
                end
                S_CLR:
                begin
                    if (clr_cnt_reg == XW'(LINE_WIDTH - 1))
                    begin
                        clr_cnt_reg             <= '0;
                        dirty_reg[clr_slot_reg] <= 1'b0;
                        if (clr2_v_reg)
                        begin
                            clr_slot_reg <= clr2_slot_reg;
                            clr2_v_reg   <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ret_slide_reg ? S_SLIDE : S_WIPE;
                        end
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_WIPE:
                begin
                    if (dirty_reg[wipe_idx_reg])
                    begin
                        clr_slot_reg  <= wipe_idx_reg;
                        clr2_v_reg    <= 1'b0;
                        clr_cnt_reg   <= '0;
                        ret_slide_reg <= 1'b0;
                        state_reg     <= S_CLR;
                    end
                    else if (wipe_idx_reg == SLOT_W'(NSLOT - 1))
                    begin
                        wipe_req_reg <= 1'b0;
                        state_reg    <= wipe_item_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        wipe_idx_reg <= wipe_idx_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    out_found_reg <= (src_reg != SRC_NONE);
                    out_row_reg   <= beam_line_reg;
                    out_col_reg   <= beam_pixel_reg;
                    case (src_reg)
                        SRC_STORE: out_pixel_reg <= store_pix;
                        SRC_FRAME: out_pixel_reg <= fr_rdata;
                        default:   out_pixel_reg <= '0;
                    endcase
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel        = out_pixel_reg;
    assign found        = out_found_reg;
    assign beam_row     = out_row_reg;
    assign beam_col     = out_col_reg;

endmodule
`default_nettype wire
